### src/soa_pkg.sv
package soa_pkg;

	localparam int SLAB_SLOTS  = 64;
	localparam int MAX_OBJECTS = 256;
	localparam int SLAB_W      = $clog2(SLAB_SLOTS);
	localparam int SPTR_W      = SLAB_W + 1;
	localparam int OBJ_W       = $clog2(MAX_OBJECTS);
	localparam int OPTR_W      = OBJ_W + 1;
	localparam int OADDR_W     = SLAB_W + OBJ_W;
	localparam int CNT_W       = OPTR_W;
	localparam int COL_W       = 8;
	localparam int ORD_W       = 4;
	localparam int BLK_W       = 19;
	localparam int PER_W       = 13;
	localparam int ORDER_MAX   = 12;
	localparam int CFG_W       = 9;
	localparam int CFG_IDX_W   = 2;

	localparam logic [SPTR_W-1:0] NONE_SLAB  = SPTR_W'(SLAB_SLOTS);
	localparam logic [OPTR_W-1:0] CHAIN_END  = OPTR_W'(MAX_OBJECTS);
	localparam logic [BLK_W-1:0]  BLOCKS_MAX = {BLK_W{1'b1}};

	typedef enum logic [1:0] {
		REQ_ALLOC  = 2'd0,
		REQ_FREE   = 2'd1,
		REQ_SHRINK = 2'd2,
		REQ_NONE   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_SLOT   = 2'd1,
		STAT_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SLAB_UNUSED  = 2'd0,
		SLAB_FREE    = 2'd1,
		SLAB_PARTIAL = 2'd2,
		SLAB_FULL    = 2'd3
	} slab_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OBJECTS = 2'd0,
		CFG_COLOURS = 2'd1,
		CFG_ORDER   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [CNT_W-1:0] slab_capacity;
		logic [COL_W-1:0] colour_count;
		logic [ORD_W-1:0] slab_order;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [SLAB_W-1:0] slab_id;
		logic [OBJ_W-1:0]  item_index;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLAB_W-1:0] slab_id_out;
		logic [OBJ_W-1:0]  item_index_out;
		logic [COL_W-1:0]  colour_slot;
		logic [BLK_W-1:0]  blocks_released;
	} res_t;

endpackage

### src/soa_req_if.sv
interface soa_req_if
	import soa_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [SLAB_W-1:0] slab_id;
	logic [OBJ_W-1:0]  item_index;

	modport source (output valid, req_type, slab_id, item_index, input ready);
	modport sink (input valid, req_type, slab_id, item_index, output ready);
endinterface

### src/soa_res_if.sv
interface soa_res_if
	import soa_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [SLAB_W-1:0] slab_id_out;
	logic [OBJ_W-1:0]  item_index_out;
	logic [COL_W-1:0]  colour_slot;
	logic [BLK_W-1:0]  blocks_released;

	modport source (output valid, status, slab_id_out, item_index_out, colour_slot,
		blocks_released, input ready);
	modport sink (input valid, status, slab_id_out, item_index_out, colour_slot,
		blocks_released, output ready);
endinterface

### src/soa_engine.sv
module soa_engine
	import soa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	input  logic out_free,
	output logic out_done,
	output res_t out_res
);

	typedef enum logic [4:0] {
		S_IDLE, S_A_FREE_RD, S_A_FREE_WR, S_SCAN, S_NEW, S_INIT,
		S_POP_RD, S_POP_OBJ, S_POP_UPD,
		S_UNL_RDS, S_UNL_GETS, S_UNL_RD, S_UNL_CHK, S_PUSH,
		S_F_RD, S_F_CHK, S_F_OBJ,
		S_SH_CHK, S_SH_NXT, S_DONE
	} state_t;

	state_t             state_q;
	logic [1:0]         kind_q;
	logic [SLAB_W-1:0]  s_q;
	logic [OBJ_W-1:0]   idx_q;
	logic [SPTR_W-1:0]  cur_q;
	logic [SPTR_W-1:0]  steps_q;
	logic [SPTR_W-1:0]  sn_q;
	logic               ulst_q;
	logic [OPTR_W-1:0]  ff_q;
	logic [CNT_W-1:0]   uc_q;
	logic [OPTR_W-1:0]  ini_q;
	logic [SPTR_W-1:0]  ph_q;
	logic [SPTR_W-1:0]  fh_q;
	logic [SPTR_W-1:0]  fuh_q;
	logic [COL_W-1:0]   cc_q;
	logic               grow_q;
	logic [SLAB_SLOTS-1:0] vld_q;
	res_t               res_q;

	logic [SPTR_W-1:0] nxt_mem [SLAB_SLOTS];
	logic [OPTR_W-1:0] ff_mem  [SLAB_SLOTS];
	logic [CNT_W-1:0]  uc_mem  [SLAB_SLOTS];
	logic [COL_W-1:0]  col_mem [SLAB_SLOTS];
	logic [1:0]        st_mem  [SLAB_SLOTS];
	logic [OPTR_W-1:0] obj_mem [SLAB_SLOTS*MAX_OBJECTS];

	logic [SPTR_W-1:0]  nxt_rd_q;
	logic [OPTR_W-1:0]  ff_rd_q;
	logic [CNT_W-1:0]   uc_rd_q;
	logic [COL_W-1:0]   col_rd_q;
	logic [1:0]         st_rd_q;
	logic [OPTR_W-1:0]  obj_rd_q;

	logic               nxt_we, ff_we, uc_we, col_we, st_we, obj_we;
	logic [SLAB_W-1:0]  nxt_ra, nxt_wa;
	logic [SPTR_W-1:0]  nxt_wd;
	logic [OPTR_W-1:0]  ff_wd;
	logic [CNT_W-1:0]   uc_wd;
	logic [1:0]         st_wd;
	logic [OADDR_W-1:0] obj_ra, obj_wa;
	logic [OPTR_W-1:0]  obj_wd;

	logic [CNT_W-1:0]   n_eff;
	logic [ORD_W-1:0]   ord_eff;
	logic [PER_W-1:0]   per;
	logic [BLK_W:0]     tot_sum;
	logic [SPTR_W-1:0]  hd;
	logic [OBJ_W-1:0]   pop_idx;
	logic [1:0]         st_cur;
	logic [CNT_W-1:0]   uc_dec;
	logic [CNT_W:0]     cc_inc;

	assign n_eff = (cfg.slab_capacity == '0) ? CNT_W'(1) :
		(cfg.slab_capacity > CNT_W'(MAX_OBJECTS)) ? CNT_W'(MAX_OBJECTS) :
		cfg.slab_capacity;
	assign ord_eff = (cfg.slab_order > ORD_W'(ORDER_MAX)) ? ORD_W'(ORDER_MAX) : cfg.slab_order;
	assign per     = PER_W'(1) << ord_eff;
	assign tot_sum = {1'b0, res_q.blocks_released} + (BLK_W+1)'(per);
	assign hd      = ulst_q ? fuh_q : ph_q;
	assign pop_idx = (ff_rd_q >= CHAIN_END) ? '0 : ff_rd_q[OBJ_W-1:0];
	assign st_cur  = vld_q[s_q] ? st_rd_q : SLAB_UNUSED;
	assign uc_dec  = (uc_rd_q != '0) ? uc_rd_q - CNT_W'(1) : '0;
	assign cc_inc  = {1'b0, cc_q} + (CNT_W+1)'(1);

	assign in_ready = (state_q == S_IDLE);
	assign out_done = (state_q == S_DONE) && out_free;
	assign out_res  = res_q;

	always_comb begin
		nxt_we = 1'b0; nxt_ra = s_q; nxt_wa = s_q; nxt_wd = ph_q;
		ff_we  = 1'b0; ff_wd = '0;
		uc_we  = 1'b0; uc_wd = '0;
		col_we = 1'b0;
		st_we  = 1'b0; st_wd = SLAB_PARTIAL;
		obj_we = 1'b0; obj_wa = {s_q, idx_q}; obj_wd = ff_q;
		obj_ra = {s_q, pop_idx};
		unique case (state_q)
			S_A_FREE_WR: begin
				nxt_we = 1'b1;
				st_we  = 1'b1;
			end
			S_NEW: begin
				nxt_we = 1'b1;
				st_we  = 1'b1;
				uc_we  = 1'b1;
				col_we = 1'b1;
				ff_we  = 1'b1;
			end
			S_INIT: begin
				obj_we = 1'b1;
				obj_wa = {s_q, ini_q[OBJ_W-1:0]};
				obj_wd = (ini_q == n_eff - CNT_W'(1)) ? CHAIN_END : ini_q + OPTR_W'(1);
			end
			S_POP_UPD: begin
				ff_we = 1'b1;
				ff_wd = obj_rd_q;
				uc_we = 1'b1;
				uc_wd = uc_q;
			end
			S_UNL_RD, S_SH_CHK: nxt_ra = cur_q[SLAB_W-1:0];
			S_UNL_CHK: begin
				nxt_we = (nxt_rd_q == {1'b0, s_q});
				nxt_wa = cur_q[SLAB_W-1:0];
				nxt_wd = sn_q;
			end
			S_PUSH: begin
				nxt_we = 1'b1;
				st_we  = 1'b1;
				if (kind_q == REQ_ALLOC) begin
					nxt_wd = fuh_q;
					st_wd  = SLAB_FULL;
				end else if (uc_q == '0) begin
					nxt_wd = fh_q;
					st_wd  = SLAB_FREE;
				end
			end
			S_F_CHK: begin
				uc_we = (st_cur == SLAB_PARTIAL) || (st_cur == SLAB_FULL);
				uc_wd = uc_dec;
			end
			S_F_OBJ: begin
				obj_we = 1'b1;
				ff_we  = 1'b1;
				ff_wd  = {1'b0, idx_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		nxt_rd_q <= nxt_mem[nxt_ra];
	end

	always_ff @(posedge clk) begin
		if (ff_we) ff_mem[s_q] <= ff_wd;
		ff_rd_q <= ff_mem[s_q];
	end

	always_ff @(posedge clk) begin
		if (uc_we) uc_mem[s_q] <= uc_wd;
		uc_rd_q <= uc_mem[s_q];
	end

	always_ff @(posedge clk) begin
		if (col_we) col_mem[s_q] <= cc_q;
		col_rd_q <= col_mem[s_q];
	end

	always_ff @(posedge clk) begin
		if (st_we) st_mem[s_q] <= st_wd;
		st_rd_q <= st_mem[s_q];
	end

	always_ff @(posedge clk) begin
		if (obj_we) obj_mem[obj_wa] <= obj_wd;
		obj_rd_q <= obj_mem[obj_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= NONE_SLAB;
			fh_q    <= NONE_SLAB;
			fuh_q   <= NONE_SLAB;
			cc_q    <= '0;
			grow_q  <= 1'b0;
			vld_q   <= '0;
			kind_q  <= REQ_NONE;
			s_q     <= '0;
			idx_q   <= '0;
			cur_q   <= '0;
			steps_q <= '0;
			sn_q    <= '0;
			ulst_q  <= 1'b0;
			ff_q    <= '0;
			uc_q    <= '0;
			ini_q   <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q <= in_req.req_type;
						s_q    <= in_req.slab_id;
						idx_q  <= in_req.item_index;
						res_q  <= '0;
						unique case (in_req.req_type)
							REQ_ALLOC: begin
								if (ph_q < NONE_SLAB) begin
									s_q     <= ph_q[SLAB_W-1:0];
									state_q <= S_POP_RD;
								end else if (fh_q < NONE_SLAB) begin
									s_q     <= fh_q[SLAB_W-1:0];
									state_q <= S_A_FREE_RD;
								end else begin
									cur_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							REQ_FREE: begin
								if ({1'b0, in_req.item_index} >= n_eff) begin
									res_q.status <= STAT_NOT_FOUND;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_F_RD;
								end
							end
							REQ_SHRINK: begin
								if (grow_q) begin
									grow_q  <= 1'b0;
									state_q <= S_DONE;
								end else begin
									cur_q   <= fh_q;
									steps_q <= '0;
									state_q <= S_SH_CHK;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_A_FREE_RD: state_q <= S_A_FREE_WR;
				S_A_FREE_WR: begin
					fh_q    <= nxt_rd_q;
					ph_q    <= {1'b0, s_q};
					state_q <= S_POP_RD;
				end
				S_SCAN: begin
					if (!vld_q[cur_q[SLAB_W-1:0]]) begin
						s_q     <= cur_q[SLAB_W-1:0];
						state_q <= S_NEW;
					end else if (cur_q[SLAB_W-1:0] == SLAB_W'(SLAB_SLOTS - 1)) begin
						res_q.status <= STAT_NO_SLOT;
						state_q      <= S_DONE;
					end else begin
						cur_q <= cur_q + SPTR_W'(1);
					end
				end
				S_NEW: begin
					vld_q[s_q] <= 1'b1;
					grow_q     <= 1'b1;
					ph_q       <= {1'b0, s_q};
					cc_q       <= (cc_inc > {1'b0, cfg.colour_count}) ? '0 : cc_inc[COL_W-1:0];
					ini_q      <= '0;
					state_q    <= S_INIT;
				end
				S_INIT: begin
					if (ini_q == n_eff - CNT_W'(1)) begin
						state_q <= S_POP_RD;
					end else begin
						ini_q <= ini_q + OPTR_W'(1);
					end
				end
				S_POP_RD: state_q <= S_POP_OBJ;
				S_POP_OBJ: begin
					res_q.item_index_out <= pop_idx;
					res_q.colour_slot    <= col_rd_q;
					res_q.slab_id_out    <= s_q;
					uc_q                 <= uc_rd_q + CNT_W'(1);
					state_q              <= S_POP_UPD;
				end
				S_POP_UPD: begin
					if ((uc_q >= n_eff) || (obj_rd_q >= CHAIN_END)) begin
						ulst_q  <= 1'b0;
						state_q <= S_UNL_RDS;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_UNL_RDS: state_q <= S_UNL_GETS;
				S_UNL_GETS: begin
					sn_q    <= nxt_rd_q;
					cur_q   <= hd;
					steps_q <= '0;
					if (hd == {1'b0, s_q}) begin
						if (ulst_q) fuh_q <= nxt_rd_q;
						else ph_q <= nxt_rd_q;
						state_q <= S_PUSH;
					end else if (hd >= NONE_SLAB) begin
						state_q <= S_PUSH;
					end else begin
						state_q <= S_UNL_RD;
					end
				end
				S_UNL_RD: state_q <= S_UNL_CHK;
				S_UNL_CHK: begin
					if (nxt_rd_q == {1'b0, s_q}) begin
						state_q <= S_PUSH;
					end else begin
						cur_q   <= nxt_rd_q;
						steps_q <= steps_q + SPTR_W'(1);
						if ((nxt_rd_q >= NONE_SLAB) || (steps_q == SPTR_W'(SLAB_SLOTS - 1)))
							state_q <= S_PUSH;
						else
							state_q <= S_UNL_RD;
					end
				end
				S_PUSH: begin
					if (kind_q == REQ_ALLOC) begin
						fuh_q   <= {1'b0, s_q};
						state_q <= S_DONE;
					end else begin
						if (uc_q == '0) fh_q <= {1'b0, s_q};
						else ph_q <= {1'b0, s_q};
						state_q <= S_F_OBJ;
					end
				end
				S_F_RD: state_q <= S_F_CHK;
				S_F_CHK: begin
					uc_q <= uc_dec;
					ff_q <= ff_rd_q;
					if (st_cur == SLAB_PARTIAL) begin
						ulst_q  <= 1'b0;
						state_q <= (uc_dec == '0) ? S_UNL_RDS : S_F_OBJ;
					end else if (st_cur == SLAB_FULL) begin
						ulst_q  <= 1'b1;
						state_q <= S_UNL_RDS;
					end else begin
						res_q.status <= STAT_NOT_FOUND;
						state_q      <= S_DONE;
					end
				end
				S_F_OBJ: state_q <= S_DONE;
				S_SH_CHK: begin
					if ((cur_q >= NONE_SLAB) || (steps_q == SPTR_W'(SLAB_SLOTS))) begin
						fh_q    <= NONE_SLAB;
						state_q <= S_DONE;
					end else begin
						vld_q[cur_q[SLAB_W-1:0]] <= 1'b0;
						res_q.blocks_released <= (tot_sum > {1'b0, BLOCKS_MAX}) ?
							BLOCKS_MAX : tot_sum[BLK_W-1:0];
						state_q <= S_SH_NXT;
					end
				end
				S_SH_NXT: begin
					cur_q   <= nxt_rd_q;
					steps_q <= steps_q + SPTR_W'(1);
					state_q <= S_SH_CHK;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### src/slab_object_allocator_core.sv
// channel | dir | payload                                                      | transaction
// req     | in  | req_type, slab_id, item_index                                | valid & ready
// res     | out | status, slab_id_out, item_index_out, colour_slot, blocks_rel | valid & ready
// cfg     | in  | cfg_index, cfg_data                                          | cfg_we
// one request at a time; an alloc from a free slab first moves that slab to the partial list
// a new slab adds a scan for an unused slot, a setup step and the build of its object chain
// moving a slab between lists walks the list, reading each slab's link from the slab link memory
// shrink releases each slab on the free list, or only clears the grow mark if a slab was made since
// the last shrink; reset clears lists and slab valid bits at once
// the engine takes a new request while the previous result waits on res.ready
module slab_object_allocator_core
	import soa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	soa_req_if.sink              req,
	soa_res_if.source            res
);

	cfg_t cfg_q;
	logic out_vld_q;
	res_t out_q;
	logic out_free;
	logic eng_done;
	res_t eng_res;
	req_t in_req;

	assign in_req   = '{req_type: req.req_type, slab_id: req.slab_id, item_index: req.item_index};
	assign out_free = !out_vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slab_capacity <= CNT_W'(1);
			cfg_q.colour_count  <= '0;
			cfg_q.slab_order    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OBJECTS: cfg_q.slab_capacity <= cfg_data[CNT_W-1:0];
				CFG_COLOURS: cfg_q.colour_count <= cfg_data[COL_W-1:0];
				CFG_ORDER:   cfg_q.slab_order <= cfg_data[ORD_W-1:0];
				default: ;
			endcase
		end
	end

	soa_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_req   (in_req),
		.out_free (out_free),
		.out_done (eng_done),
		.out_res  (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else if (out_free) begin
			out_vld_q <= eng_done;
			if (eng_done) out_q <= eng_res;
		end
	end

	assign res.valid           = out_vld_q;
	assign res.status          = out_q.status;
	assign res.slab_id_out     = out_q.slab_id_out;
	assign res.item_index_out  = out_q.item_index_out;
	assign res.colour_slot     = out_q.colour_slot;
	assign res.blocks_released = out_q.blocks_released;

endmodule
